>>> sv/park_pkg.sv
// Shared types, constants and functions for the Park rotation block.
package park_pkg;

    localparam int SINE_TABLE_BITS_DEF = 8;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    typedef struct packed {
        logic              kind;
        logic signed [15:0] in_x;
        logic signed [15:0] in_y;
        logic [15:0]        angle;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] out_x;
        logic signed [15:0] out_y;
        logic               saturated;
    } t_out_item;

    typedef struct packed {
        logic signed [15:0] value;
        logic               clip;
    } t_sat_res;

    localparam logic KIND_FORWARD = 1'b0;
    localparam logic KIND_INVERSE = 1'b1;

    // Quarter-wave sine entry in unsigned Q0.15, evaluated at elaboration only.
    function automatic logic [14:0] sine_entry(input int unsigned k, input int unsigned qbits);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t3;
        logic [63:0] t5;
        logic [63:0] t7;
        logic [63:0] t9;
        logic [63:0] t11;
        logic [63:0] t13;
        logic [63:0] pos;
        logic [63:0] neg;
        logic [63:0] r;
        x   = (HALF_PI_Q30 * 64'(k)) >> qbits;
        x2  = (x * x) >> 30;
        t3  = ((x * x2) >> 30) / 64'd6;
        t5  = ((t3 * x2) >> 30) / 64'd20;
        t7  = ((t5 * x2) >> 30) / 64'd42;
        t9  = ((t7 * x2) >> 30) / 64'd72;
        t11 = ((t9 * x2) >> 30) / 64'd110;
        t13 = ((t11 * x2) >> 30) / 64'd156;
        pos = x + t5 + t9 + t13;
        neg = t3 + t7 + t11;
        r   = (pos > neg) ? pos - neg : 64'd0;
        r   = (r + 64'd16384) >> 15;
        if (r > 64'd32767) begin
            r = 64'd32767;
        end
        return r[14:0];
    endfunction

    // Rounds a Q3.30 sum half up to Q1.15 and clips it to 16 bits.
    function automatic t_sat_res round_sat(input logic signed [32:0] sum);
        logic signed [33:0] biased;
        logic signed [18:0] shifted;
        t_sat_res res;
        biased  = 34'(sum) + 34'sd16384;
        shifted = 19'(biased >>> 15);
        if (shifted > 19'sd32767) begin
            res.value = 16'sh7FFF;
            res.clip  = 1'b1;
        end else if (shifted < -19'sd32768) begin
            res.value = 16'sh8000;
            res.clip  = 1'b1;
        end else begin
            res.value = shifted[15:0];
            res.clip  = 1'b0;
        end
        return res;
    endfunction

endpackage

>>> sv/park_if.sv
// Valid/ready channel interfaces for the input and result transactions.
interface park_in_if import park_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface park_out_if import park_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> sv/park_trig.sv
// Sine and cosine lookup from a quarter-wave table built at elaboration.
module park_trig import park_pkg::*; #(
    parameter int SINE_TABLE_BITS = SINE_TABLE_BITS_DEF
) (
    input  logic [15:0]        i_angle,
    output logic signed [15:0] o_sin,
    output logic signed [15:0] o_cos
);

    localparam int QB = SINE_TABLE_BITS - 2;
    localparam int Q  = 1 << QB;

    logic [14:0]                w_tab [Q+1];
    logic [SINE_TABLE_BITS-1:0] w_idx;
    logic [1:0]                 w_quad;
    logic [QB:0]                w_addr_a;
    logic [QB:0]                w_addr_b;
    logic [14:0]                w_val_a;
    logic [14:0]                w_val_b;
    logic [15:0]                w_sin_mag;
    logic [15:0]                w_cos_mag;
    logic                       w_cos_neg;

    for (genvar k = 0; k <= Q; k++) begin : g_tab
        localparam logic [14:0] ENTRY = sine_entry(k, QB);
        assign w_tab[k] = ENTRY;
    end

    assign w_idx    = i_angle[15 -: SINE_TABLE_BITS];
    assign w_quad   = w_idx[SINE_TABLE_BITS-1 -: 2];
    assign w_addr_a = {1'b0, w_idx[QB-1:0]};
    assign w_addr_b = (QB+1)'(Q) - w_addr_a;
    assign w_val_a  = w_tab[w_addr_a];
    assign w_val_b  = w_tab[w_addr_b];

    // The cosine sits one quadrant ahead of the sine.
    assign w_sin_mag = {1'b0, (w_quad[0] ? w_val_b : w_val_a)};
    assign w_cos_mag = {1'b0, (w_quad[0] ? w_val_a : w_val_b)};
    assign w_cos_neg = w_quad[1] ^ w_quad[0];

    assign o_sin = w_quad[1] ? -$signed(w_sin_mag) : $signed(w_sin_mag);
    assign o_cos = w_cos_neg ? -$signed(w_cos_mag) : $signed(w_cos_mag);

endmodule

>>> sv/park_rot.sv
// Rotation datapath: four products, sums, rounding and saturation.
module park_rot import park_pkg::*; (
    input  logic               i_kind,
    input  logic signed [15:0] i_x,
    input  logic signed [15:0] i_y,
    input  logic signed [15:0] i_sin,
    input  logic signed [15:0] i_cos,
    output t_out_item          o_res
);

    logic signed [31:0] w_xc;
    logic signed [31:0] w_xs;
    logic signed [31:0] w_yc;
    logic signed [31:0] w_ys;
    logic signed [32:0] w_sum_x;
    logic signed [32:0] w_sum_y;
    t_sat_res           w_rx;
    t_sat_res           w_ry;

    assign w_xc = i_x * i_cos;
    assign w_xs = i_x * i_sin;
    assign w_yc = i_y * i_cos;
    assign w_ys = i_y * i_sin;

    always_comb begin
        if (i_kind == KIND_INVERSE) begin
            w_sum_x = 33'(w_xc) - 33'(w_ys);
            w_sum_y = 33'(w_xs) + 33'(w_yc);
        end else begin
            w_sum_x = 33'(w_xc) + 33'(w_ys);
            w_sum_y = 33'(w_yc) - 33'(w_xs);
        end
    end

    assign w_rx = round_sat(w_sum_x);
    assign w_ry = round_sat(w_sum_y);

    assign o_res.out_x     = w_rx.value;
    assign o_res.out_y     = w_ry.value;
    assign o_res.saturated = w_rx.clip | w_ry.clip;

endmodule

>>> sv/park_rotation.sv
// Top level of the forward and inverse Park rotation block.
// An accepted input transaction passes the input register and then the result register to the output.
// Throughput: one transaction per cycle while the output is ready; the angle lookup happens before the input
// register and the four multipliers, rounding and saturation sit before the result register.
// Reset clears both valid flags and holds the input not ready; the data registers are not
// reset, and the block is ready in the first cycle after reset.
module park_rotation import park_pkg::*; #(
    parameter int SINE_TABLE_BITS = SINE_TABLE_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    park_in_if.sink     i_in,
    park_out_if.source  o_out
);

    logic               r_in_valid;
    logic               r_kind;
    logic signed [15:0] r_x;
    logic signed [15:0] r_y;
    logic signed [15:0] r_sin;
    logic signed [15:0] r_cos;
    logic               r_out_valid;
    t_out_item          r_out;

    logic               n_in_valid;
    logic               n_out_valid;
    logic               w_adv_out;
    logic               w_take;
    logic signed [15:0] w_sin;
    logic signed [15:0] w_cos;
    t_out_item          w_res;

    park_trig #(
        .SINE_TABLE_BITS(SINE_TABLE_BITS)
    ) u_trig (
        .i_angle (i_in.data.angle),
        .o_sin   (w_sin),
        .o_cos   (w_cos)
    );

    park_rot u_rot (
        .i_kind (r_kind),
        .i_x    (r_x),
        .i_y    (r_y),
        .i_sin  (r_sin),
        .i_cos  (r_cos),
        .o_res  (w_res)
    );

    assign w_adv_out   = !r_out_valid || o_out.ready;
    assign i_in.ready  = i_rst_n && (!r_in_valid || w_adv_out);
    assign w_take      = i_in.valid && i_in.ready;
    assign n_in_valid  = w_take ? 1'b1 : (w_adv_out ? 1'b0 : r_in_valid);
    assign n_out_valid = w_adv_out ? r_in_valid : r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_kind <= i_in.data.kind;
            r_x    <= i_in.data.in_x;
            r_y    <= i_in.data.in_y;
            r_sin  <= w_sin;
            r_cos  <= w_cos;
        end
        if (w_adv_out && r_in_valid) begin
            r_out <= w_res;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

endmodule
